// ===== sv/chm_pkg.sv =====
// Package for the chained scatter hash map core.
// Holds default sizes, command codes and the sequencer state type. No dependencies.
`default_nettype none
package chm_pkg;

  localparam int unsigned SlotsDef     = 256;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned CmdBits      = 2;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD    = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_APPLY,
    ST_DEL_PREV,
    ST_DEL_N,
    ST_DEL_CLR,
    ST_INS_RS,
    ST_INS_S,
    ST_SCAN,
    ST_SCAN_D,
    ST_EV_RD,
    ST_EV_W,
    ST_EV_H,
    ST_EV_HD,
    ST_EV_C,
    ST_EV_HL,
    ST_NEW_C,
    ST_NEW_S,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

// ===== sv/chm_if.sv =====
// Valid/ready channel interfaces for command words and result words.
// Depends on chm_pkg for default widths.
`default_nettype none
interface chm_in_if #(
  parameter int unsigned KEY_BITS   = chm_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = chm_pkg::ValueBitsDef
);
  logic                          valid;
  logic                          ready;
  logic [chm_pkg::CmdBits-1:0]   command;
  logic [KEY_BITS-1:0]           key;
  logic [VALUE_BITS-1:0]         value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface chm_out_if #(
  parameter int unsigned VALUE_BITS = chm_pkg::ValueBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value_out;
  logic                  hit;
  logic                  status;

  modport source (output valid, value_out, hit, status, input ready);
  modport sink   (input valid, value_out, hit, status, output ready);
endinterface
`default_nettype wire

// ===== sv/chm_mem.sv =====
// Slot memory: one write port, one read port with registered read data.
// Depends on chm_pkg for the default depth; used by chained_scatter_hash_map_core.
`default_nettype none
module chm_mem #(
  parameter int unsigned DEPTH = chm_pkg::SlotsDef,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/chm_seq.sv =====
// Operation sequencer: walks chains, scans the free cursor and edits slots
// through read-modify-write on chm_mem. Depends on chm_pkg.
`default_nettype none
module chm_seq #(
  parameter int unsigned SLOTS      = chm_pkg::SlotsDef,
  parameter int unsigned KEY_BITS   = chm_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = chm_pkg::ValueBitsDef,
  localparam int unsigned AW        = $clog2(SLOTS),
  localparam int unsigned EW        = 2 + KEY_BITS + VALUE_BITS + AW
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [chm_pkg::CmdBits-1:0] in_command_i,
  input  wire logic [KEY_BITS-1:0]         in_key_i,
  input  wire logic [VALUE_BITS-1:0]       in_value_i,
  input  wire logic                        out_free_i,
  output logic                             res_valid_o,
  output logic [VALUE_BITS-1:0]            res_value_o,
  output logic                             res_hit_o,
  output logic                             res_status_o,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_waddr_o,
  output logic [EW-1:0]                    mem_wdata_o,
  output logic [AW-1:0]                    mem_raddr_o,
  input  wire logic [EW-1:0]               mem_rdata_i
);

  typedef struct packed {
    logic                  used;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic                  lok;
    logic [AW-1:0]         lidx;
  } ent_t;

  localparam logic [AW-1:0] LastIdx = AW'(SLOTS - 1);

  chm_pkg::state_e state_q, state_d;

  logic [chm_pkg::CmdBits-1:0] cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [AW-1:0]   cur_q, prev_q, f_q, c_q, p_q, clr_q, tgt_q, steps_q;
  logic            prev_ok_q;
  logic [AW:0]     sc_q, fc_q;
  ent_t            fent_q, pent_q, sent_q, hent_q;
  logic [VALUE_BITS-1:0] rv_q;
  logic            hit_q, st_q;

  ent_t       rd;
  ent_t       ent_w;
  ent_t       empty_ent;
  logic [63:0] in_key64, key64, skey64;
  logic [AW-1:0] in_main, s_main, h_main;
  logic       match, chain_end, ev_hit, ev_end;

  assign rd        = ent_t'(mem_rdata_i);
  assign in_key64  = 64'(in_key_i);
  assign key64     = 64'(key_q);
  assign skey64    = 64'(sent_q.key);
  assign in_main   = in_key64[AW-1:0];
  assign s_main    = key64[AW-1:0];
  assign h_main    = skey64[AW-1:0];
  assign match     = rd.used && (rd.key == key_q);
  assign chain_end = !rd.lok || (steps_q == LastIdx);
  assign ev_hit    = rd.lok && (rd.lidx == s_main);
  assign ev_end    = !rd.lok || (steps_q == LastIdx);

  always_comb begin
    empty_ent       = '0;
    empty_ent.lok   = 1'b0;
    empty_ent.lidx  = '1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      chm_pkg::ST_CLEAR: begin
        if (clr_q == LastIdx) state_d = chm_pkg::ST_IDLE;
      end
      chm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_command_i == chm_pkg::CMD_ADD || in_command_i == chm_pkg::CMD_QUERY ||
              in_command_i == chm_pkg::CMD_DELETE) begin
            state_d = chm_pkg::ST_FIND;
          end else begin
            state_d = chm_pkg::ST_RESP;
          end
        end
      end
      chm_pkg::ST_FIND: begin
        if (match) begin
          state_d = chm_pkg::ST_APPLY;
        end else if (chain_end) begin
          state_d = (cmd_q == chm_pkg::CMD_ADD) ? chm_pkg::ST_INS_RS : chm_pkg::ST_RESP;
        end
      end
      chm_pkg::ST_APPLY: begin
        if (cmd_q == chm_pkg::CMD_DELETE) begin
          if (prev_ok_q)        state_d = chm_pkg::ST_DEL_PREV;
          else if (fent_q.lok)  state_d = chm_pkg::ST_DEL_N;
          else                  state_d = chm_pkg::ST_DEL_CLR;
        end else begin
          state_d = chm_pkg::ST_RESP;
        end
      end
      chm_pkg::ST_DEL_PREV: state_d = chm_pkg::ST_DEL_CLR;
      chm_pkg::ST_DEL_N:    state_d = chm_pkg::ST_DEL_CLR;
      chm_pkg::ST_DEL_CLR:  state_d = chm_pkg::ST_RESP;
      chm_pkg::ST_INS_RS:   state_d = chm_pkg::ST_INS_S;
      chm_pkg::ST_INS_S: begin
        state_d = rd.used ? chm_pkg::ST_SCAN : chm_pkg::ST_RESP;
      end
      chm_pkg::ST_SCAN: begin
        state_d = (sc_q == '0) ? chm_pkg::ST_RESP : chm_pkg::ST_SCAN_D;
      end
      chm_pkg::ST_SCAN_D: begin
        if (rd.used)                 state_d = chm_pkg::ST_SCAN;
        else if (h_main != s_main)   state_d = chm_pkg::ST_EV_RD;
        else                         state_d = chm_pkg::ST_NEW_C;
      end
      chm_pkg::ST_EV_RD: state_d = chm_pkg::ST_EV_W;
      chm_pkg::ST_EV_W: begin
        if (ev_hit || ev_end) state_d = chm_pkg::ST_EV_H;
      end
      chm_pkg::ST_EV_H:  state_d = chm_pkg::ST_EV_HD;
      chm_pkg::ST_EV_HD: state_d = chm_pkg::ST_EV_C;
      chm_pkg::ST_EV_C: begin
        state_d = (c_q == h_main) ? chm_pkg::ST_RESP : chm_pkg::ST_EV_HL;
      end
      chm_pkg::ST_EV_HL: state_d = chm_pkg::ST_RESP;
      chm_pkg::ST_NEW_C: state_d = chm_pkg::ST_NEW_S;
      chm_pkg::ST_NEW_S: state_d = chm_pkg::ST_RESP;
      chm_pkg::ST_RESP: begin
        if (out_free_i) state_d = chm_pkg::ST_IDLE;
      end
      default: state_d = chm_pkg::ST_CLEAR;
    endcase
  end

  // Memory port and handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = f_q;
    mem_raddr_o = cur_q;
    ent_w       = empty_ent;
    case (state_q)
      chm_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
      end
      chm_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = in_main;
      end
      chm_pkg::ST_FIND: begin
        mem_raddr_o = rd.lidx;
      end
      chm_pkg::ST_APPLY: begin
        mem_raddr_o = fent_q.lidx;
        if (cmd_q == chm_pkg::CMD_ADD && fent_q.value != val_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = f_q;
          ent_w       = fent_q;
          ent_w.value = val_q;
        end
      end
      chm_pkg::ST_DEL_PREV: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = prev_q;
        ent_w       = pent_q;
        ent_w.lok   = fent_q.lok;
        ent_w.lidx  = fent_q.lidx;
      end
      chm_pkg::ST_DEL_N: begin
        // pull the successor into the head slot
        mem_we_o    = 1'b1;
        mem_waddr_o = f_q;
        ent_w       = rd;
      end
      chm_pkg::ST_DEL_CLR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q;
      end
      chm_pkg::ST_INS_RS: begin
        mem_raddr_o = s_main;
      end
      chm_pkg::ST_INS_S: begin
        if (!rd.used) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = s_main;
          ent_w       = rd;
          ent_w.used  = 1'b1;
          ent_w.key   = key_q;
          ent_w.value = val_q;
        end
      end
      chm_pkg::ST_SCAN: begin
        mem_raddr_o = sc_q[AW-1:0] - AW'(1);
      end
      chm_pkg::ST_EV_RD: begin
        mem_raddr_o = p_q;
      end
      chm_pkg::ST_EV_W: begin
        mem_raddr_o = rd.lidx;
        if (ev_hit) begin
          // unlink the squatter from its own chain
          mem_we_o    = 1'b1;
          mem_waddr_o = p_q;
          ent_w       = rd;
          ent_w.lok   = sent_q.lok;
          ent_w.lidx  = sent_q.lidx;
        end
      end
      chm_pkg::ST_EV_H: begin
        mem_raddr_o = h_main;
      end
      chm_pkg::ST_EV_HD: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = s_main;
        ent_w.used  = 1'b1;
        ent_w.key   = key_q;
        ent_w.value = val_q;
      end
      chm_pkg::ST_EV_C: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = c_q;
        ent_w.used  = 1'b1;
        ent_w.key   = sent_q.key;
        ent_w.value = sent_q.value;
        if (c_q == h_main) begin
          ent_w.lok  = 1'b1;
          ent_w.lidx = c_q;
        end else begin
          ent_w.lok  = hent_q.lok;
          ent_w.lidx = hent_q.lidx;
        end
      end
      chm_pkg::ST_EV_HL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = h_main;
        ent_w       = hent_q;
        ent_w.lok   = 1'b1;
        ent_w.lidx  = c_q;
      end
      chm_pkg::ST_NEW_C: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = c_q;
        ent_w.used  = 1'b1;
        ent_w.key   = key_q;
        ent_w.value = val_q;
        ent_w.lok   = sent_q.lok;
        ent_w.lidx  = sent_q.lidx;
      end
      chm_pkg::ST_NEW_S: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = s_main;
        ent_w       = sent_q;
        ent_w.lok   = 1'b1;
        ent_w.lidx  = c_q;
      end
      chm_pkg::ST_RESP: begin
        res_valid_o = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    mem_wdata_o = EW'(ent_w);
  end

  assign res_value_o  = rv_q;
  assign res_hit_o    = hit_q;
  assign res_status_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chm_pkg::ST_CLEAR;
      clr_q   <= '0;
      fc_q    <= (AW+1)'(SLOTS);
    end else begin
      state_q <= state_d;
      if (state_q == chm_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      case (state_q)
        chm_pkg::ST_APPLY: begin
          if (cmd_q == chm_pkg::CMD_DELETE && prev_ok_q &&
              ({1'b0, f_q} + (AW+1)'(1)) > fc_q) begin
            fc_q <= {1'b0, f_q} + (AW+1)'(1);
          end
          if (cmd_q == chm_pkg::CMD_DELETE && !prev_ok_q && fent_q.lok &&
              ({1'b0, fent_q.lidx} + (AW+1)'(1)) > fc_q) begin
            fc_q <= {1'b0, fent_q.lidx} + (AW+1)'(1);
          end
        end
        chm_pkg::ST_SCAN_D: begin
          if (!rd.used) fc_q <= sc_q - (AW+1)'(1);
        end
        default: begin
          fc_q <= fc_q;
        end
      endcase
    end
  end

  // Operation datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      chm_pkg::ST_IDLE: begin
        cmd_q     <= in_command_i;
        key_q     <= in_key_i;
        val_q     <= in_value_i;
        cur_q     <= in_main;
        prev_ok_q <= 1'b0;
        steps_q   <= '0;
        rv_q      <= '0;
        hit_q     <= 1'b0;
        st_q      <= 1'b0;
      end
      chm_pkg::ST_FIND: begin
        if (match) begin
          f_q    <= cur_q;
          fent_q <= rd;
          hit_q  <= 1'b1;
        end else if (!chain_end) begin
          prev_q    <= cur_q;
          prev_ok_q <= 1'b1;
          pent_q    <= rd;
          cur_q     <= rd.lidx;
          steps_q   <= steps_q + AW'(1);
        end
      end
      chm_pkg::ST_APPLY: begin
        if (cmd_q != chm_pkg::CMD_ADD || fent_q.value != val_q) rv_q <= fent_q.value;
        tgt_q <= (!prev_ok_q && fent_q.lok) ? fent_q.lidx : f_q;
      end
      chm_pkg::ST_INS_S: begin
        sent_q <= rd;
        sc_q   <= fc_q;
      end
      chm_pkg::ST_SCAN: begin
        if (sc_q == '0) st_q <= 1'b1;
      end
      chm_pkg::ST_SCAN_D: begin
        if (rd.used) begin
          sc_q <= sc_q - (AW+1)'(1);
        end else begin
          c_q     <= sc_q[AW-1:0] - AW'(1);
          p_q     <= h_main;
          steps_q <= '0;
        end
      end
      chm_pkg::ST_EV_W: begin
        if (!ev_hit && !ev_end) begin
          p_q     <= rd.lidx;
          steps_q <= steps_q + AW'(1);
        end
      end
      chm_pkg::ST_EV_HD: begin
        hent_q <= rd;
      end
      default: begin
        key_q <= key_q;
      end
    endcase
  end

  cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= (AW+1)'(SLOTS))
    else $error("free cursor above table size");

  no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chm_pkg::ST_CLEAR) |-> !in_ready_o)
    else $error("input accepted during clearing pass");

  no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chm_pkg::ST_IDLE) |-> !mem_we_o)
    else $error("slot write while idle");

  full_leaves_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chm_pkg::ST_SCAN && sc_q == '0) |=> $stable(fc_q))
    else $error("rejected insert moved the free cursor");

endmodule
`default_nettype wire

// ===== sv/chained_scatter_hash_map_core.sv =====
// Chained scatter hash map core. After reset the block clears its slot memory
// and takes no word until done. Each operation reads its main slot and follows
// the chain slot by slot; one that finds its key applies the command, and a
// delete that finds its key also clears a slot and mends the links. An insert
// takes its main slot and ends there when that slot is free; otherwise the free
// cursor passes used slots until no slot is left and the insert is rejected, or
// until a free slot is found: the new entry goes there, linked from the main
// slot, or, when a squatter is evicted, the squatter moves there and is relinked
// and the new entry takes the main slot. Every access goes through the single
// read and single write port of the slot memory. One operation is in flight at
// a time; a finished result sits in an output register while the next word is
// accepted, and a result that is not taken holds the next one.
`default_nettype none
module chained_scatter_hash_map_core #(
  parameter int unsigned SLOTS      = chm_pkg::SlotsDef,
  parameter int unsigned KEY_BITS   = chm_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = chm_pkg::ValueBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  chm_in_if.sink    in_i,
  chm_out_if.source out_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned EW = 2 + KEY_BITS + VALUE_BITS + AW;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [EW-1:0]         mem_wdata, mem_rdata;
  logic                  res_valid, res_hit, res_status, out_free;
  logic [VALUE_BITS-1:0] res_value;

  logic                  ov_q;
  logic [VALUE_BITS-1:0] oval_q;
  logic                  ohit_q, ost_q;

  assign out_free = !ov_q || out_o.ready;

  chm_mem #(.DEPTH(SLOTS), .WIDTH(EW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  chm_seq #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_command_i (in_i.command),
    .in_key_i     (in_i.key),
    .in_value_i   (in_i.value),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_value_o  (res_value),
    .res_hit_o    (res_hit),
    .res_status_o (res_status),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res_valid) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      oval_q <= res_value;
      ohit_q <= res_hit;
      ost_q  <= res_status;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.value_out = oval_q;
  assign out_o.hit       = ohit_q;
  assign out_o.status    = ost_q;

endmodule
`default_nettype wire
